// ===== rtl/smtk_pkg.sv =====
package smtk_pkg;

	localparam int LOGIT_W = 16;
	localparam int EXP_W = 17;
	localparam int PROB_W = 16;
	localparam int TOP_W = 7;
	localparam int IDX_W = 6;
	localparam int RESULT_LIMIT = 64;
	localparam logic [TOP_W-1:0] TOP_COUNT_RST = 7'd5;
	localparam logic [EXP_W-1:0] EXP_CUTOFF = 17'd16384;
	localparam logic [PROB_W-1:0] PROB_MAX = 16'hFFFF;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_MAX_RD,
		ST_MAX_WT,
		ST_EXP_RD,
		ST_EXP_WT,
		ST_EXP_RUN,
		ST_DIV_RD,
		ST_DIV_WT,
		ST_DIV_RUN,
		ST_SEL_RD,
		ST_SEL_WT,
		ST_EMIT,
		ST_CLEAR
	} state_t;

	// 2^(-i/16) in Q1.16
	function automatic logic [EXP_W-1:0] pow2_lut(input logic [3:0] i);
		logic [EXP_W-1:0] v;
		case (i)
			4'd0: v = 17'd65536;
			4'd1: v = 17'd62757;
			4'd2: v = 17'd60097;
			4'd3: v = 17'd57549;
			4'd4: v = 17'd55109;
			4'd5: v = 17'd52773;
			4'd6: v = 17'd50535;
			4'd7: v = 17'd48393;
			4'd8: v = 17'd46341;
			4'd9: v = 17'd44376;
			4'd10: v = 17'd42495;
			4'd11: v = 17'd40693;
			4'd12: v = 17'd38968;
			4'd13: v = 17'd37316;
			4'd14: v = 17'd35734;
			4'd15: v = 17'd34219;
			default: v = 17'd65536;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/smtk_if.sv =====
interface smtk_in_if;
	logic valid;
	logic ready;
	logic signed [smtk_pkg::LOGIT_W-1:0] logit;
	logic last_logit;
	modport source (output valid, output logit, output last_logit, input ready);
	modport sink (input valid, input logit, input last_logit, output ready);
endinterface

interface smtk_out_if;
	logic valid;
	logic ready;
	logic [smtk_pkg::IDX_W-1:0] entry_index;
	logic [smtk_pkg::IDX_W-1:0] rank;
	logic [smtk_pkg::PROB_W-1:0] probability;
	logic last_result;
	modport source (output valid, output entry_index, output rank, output probability,
		output last_result, input ready);
	modport sink (input valid, input entry_index, input rank, input probability,
		input last_result, output ready);
endinterface

// ===== rtl/softmax_top_k_select.sv =====
// Softmax top-k selector. Logits (signed Q5.10) arrive one per transaction
// and are written to a row memory at one per cycle while input ready is high;
// transactions beyond MAX_ENTRIES are dropped, but a dropped last_logit still
// ends the row. After the last logit, with N stored entries, the block runs
// four passes. The max pass reads each entry once from the row memory. The
// exponent pass, per entry: a read, a start step and the 5-stage exp pipeline.
// The divide pass, per entry: a read, a start step, the 17-step bit-serial
// divider, then its done flag and the write-back.
// Selection then makes one scan per result: one memory read per entry, then
// loading the output register, which waits while that register is held by a
// stalled receiver. Each scan picks the best entry that ranks strictly below
// the previous pick (higher probability first, lower index on ties), so no
// per-entry marks are kept.
// A clear state follows the final result, or the divide pass when no result
// is wanted. Input ready is low from the cycle after the last logit until
// that clear state has passed. Write top_count through cfg_we / cfg_wdata
// only while the block is idle; results are emitted in descending
// probability, ties to the lower index.
module softmax_top_k_select #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [smtk_pkg::TOP_W-1:0]    cfg_wdata,
	smtk_in_if.sink                       din,
	smtk_out_if.source                    dout
);
	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int SW = smtk_pkg::EXP_W + AW;
	localparam int WW = (CW > smtk_pkg::TOP_W) ? CW : smtk_pkg::TOP_W;
	localparam int LW = smtk_pkg::LOGIT_W;
	localparam int EW = smtk_pkg::EXP_W;

	smtk_pkg::state_t state_q, state_d;

	logic [smtk_pkg::TOP_W-1:0] top_count_q;
	logic [CW-1:0]              count_q;
	logic [CW-1:0]              j_q;
	logic [WW-1:0]              k_q;
	logic [WW-1:0]              want_q;
	logic [WW-1:0]              want_d;
	logic signed [LW-1:0]       mx_q;
	logic [SW-1:0]              sum_q;
	logic                       found_q;
	logic [AW-1:0]              best_q;
	logic [smtk_pkg::PROB_W-1:0] bestp_q;
	logic [AW-1:0]              prev_idx_q;
	logic [smtk_pkg::PROB_W-1:0] prev_p_q;

	// memory ports
	logic            lr_we, vr_we;
	logic [AW-1:0]   lr_waddr, lr_raddr, vr_addr;
	logic [LW-1:0]   lr_rdata;
	logic [EW-1:0]   vr_wdata, vr_rdata;

	logic            exp_start, exp_done;
	logic [EW-1:0]   exp_e;
	logic            div_start, div_done;
	logic [EW-1:0]   div_q;

	logic            last_j;
	logic            out_free;
	logic            accept;
	logic            sel_ok;
	logic signed [LW:0] diff;
	logic [smtk_pkg::PROB_W-1:0] prob_sat;
	logic [smtk_pkg::PROB_W-1:0] cand_p;

	logic            out_valid_q;
	logic [smtk_pkg::IDX_W-1:0] out_idx_q, out_rank_q;
	logic [smtk_pkg::PROB_W-1:0] out_prob_q;
	logic            out_last_q;

	assign accept = din.valid && din.ready;
	assign last_j = (j_q == count_q - 1'b1);
	assign out_free = !out_valid_q || dout.ready;
	assign diff = (LW+1)'(mx_q) - (LW+1)'($signed(lr_rdata));
	assign prob_sat = div_q[EW-1] ? smtk_pkg::PROB_MAX : div_q[EW-2:0];
	assign cand_p = vr_rdata[smtk_pkg::PROB_W-1:0];
	// entry not yet emitted: it ranks below the previous pick
	assign sel_ok = (k_q == '0) || (cand_p < prev_p_q) ||
		(cand_p == prev_p_q && j_q[AW-1:0] > prev_idx_q);

	// clamp requested count to row length and the result limit
	always_comb begin
		want_d = WW'(top_count_q);
		if (want_d > WW'(count_q)) begin
			want_d = WW'(count_q);
		end
		if (want_d > WW'(smtk_pkg::RESULT_LIMIT)) begin
			want_d = WW'(smtk_pkg::RESULT_LIMIT);
		end
	end

	smtk_ram #(.WIDTH(LW), .DEPTH(MAX_ENTRIES)) u_logit_ram (
		.clk   (clk),
		.we    (lr_we),
		.waddr (lr_waddr),
		.wdata (din.logit),
		.raddr (lr_raddr),
		.rdata (lr_rdata)
	);

	// holds exp values, then probabilities in place
	smtk_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_value_ram (
		.clk   (clk),
		.we    (vr_we),
		.waddr (vr_addr),
		.wdata (vr_wdata),
		.raddr (vr_addr),
		.rdata (vr_rdata)
	);

	smtk_exp u_exp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (exp_start),
		.x      (diff[EW-1:0]),
		.done   (exp_done),
		.e      (exp_e)
	);

	smtk_div #(.SW(SW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (vr_rdata),
		.den    (sum_q),
		.done   (div_done),
		.q      (div_q)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			smtk_pkg::ST_LOAD: begin
				if (accept && din.last_logit) begin
					state_d = smtk_pkg::ST_MAX_RD;
				end
			end
			smtk_pkg::ST_MAX_RD: state_d = smtk_pkg::ST_MAX_WT;
			smtk_pkg::ST_MAX_WT: state_d = last_j ? smtk_pkg::ST_EXP_RD : smtk_pkg::ST_MAX_RD;
			smtk_pkg::ST_EXP_RD: state_d = smtk_pkg::ST_EXP_WT;
			smtk_pkg::ST_EXP_WT: state_d = smtk_pkg::ST_EXP_RUN;
			smtk_pkg::ST_EXP_RUN: begin
				if (exp_done) begin
					state_d = last_j ? smtk_pkg::ST_DIV_RD : smtk_pkg::ST_EXP_RD;
				end
			end
			smtk_pkg::ST_DIV_RD: state_d = smtk_pkg::ST_DIV_WT;
			smtk_pkg::ST_DIV_WT: state_d = smtk_pkg::ST_DIV_RUN;
			smtk_pkg::ST_DIV_RUN: begin
				if (div_done) begin
					if (!last_j) begin
						state_d = smtk_pkg::ST_DIV_RD;
					end else if (want_d == '0) begin
						state_d = smtk_pkg::ST_CLEAR;
					end else begin
						state_d = smtk_pkg::ST_SEL_RD;
					end
				end
			end
			smtk_pkg::ST_SEL_RD: state_d = smtk_pkg::ST_SEL_WT;
			smtk_pkg::ST_SEL_WT: state_d = last_j ? smtk_pkg::ST_EMIT : smtk_pkg::ST_SEL_RD;
			smtk_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = (k_q + 1'b1 == want_q) ? smtk_pkg::ST_CLEAR : smtk_pkg::ST_SEL_RD;
				end
			end
			smtk_pkg::ST_CLEAR: state_d = smtk_pkg::ST_LOAD;
			default: state_d = smtk_pkg::ST_LOAD;
		endcase
	end

	// outputs to memories and units
	always_comb begin
		din.ready = (state_q == smtk_pkg::ST_LOAD);
		lr_we = accept && (count_q < CW'(MAX_ENTRIES));
		lr_waddr = count_q[AW-1:0];
		lr_raddr = j_q[AW-1:0];
		vr_addr = j_q[AW-1:0];
		vr_we = 1'b0;
		vr_wdata = exp_e;
		exp_start = 1'b0;
		div_start = 1'b0;
		case (state_q)
			smtk_pkg::ST_EXP_WT: exp_start = 1'b1;
			smtk_pkg::ST_EXP_RUN: vr_we = exp_done;
			smtk_pkg::ST_DIV_WT: div_start = 1'b1;
			smtk_pkg::ST_DIV_RUN: begin
				vr_we = div_done;
				vr_wdata = EW'(prob_sat);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smtk_pkg::ST_LOAD;
			top_count_q <= smtk_pkg::TOP_COUNT_RST;
			count_q <= '0;
			j_q <= '0;
			k_q <= '0;
			want_q <= '0;
			sum_q <= '0;
			found_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				top_count_q <= cfg_wdata;
			end
			if (state_q == smtk_pkg::ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				smtk_pkg::ST_LOAD: begin
					// count stored logits; hold at MAX_ENTRIES and drop the rest
					if (lr_we) begin
						count_q <= count_q + 1'b1;
					end
					j_q <= '0;
				end
				smtk_pkg::ST_MAX_WT: begin
					j_q <= last_j ? '0 : j_q + 1'b1;
				end
				smtk_pkg::ST_EXP_RUN: begin
					if (exp_done) begin
						sum_q <= sum_q + SW'(exp_e);
						j_q <= last_j ? '0 : j_q + 1'b1;
					end
				end
				smtk_pkg::ST_DIV_RUN: begin
					if (div_done) begin
						j_q <= last_j ? '0 : j_q + 1'b1;
						want_q <= want_d;
						k_q <= '0;
						found_q <= 1'b0;
					end
				end
				smtk_pkg::ST_SEL_WT: begin
					if (sel_ok && (!found_q || cand_p > bestp_q)) begin
						found_q <= 1'b1;
					end
					j_q <= last_j ? '0 : j_q + 1'b1;
				end
				smtk_pkg::ST_EMIT: begin
					if (out_free) begin
						k_q <= k_q + 1'b1;
						found_q <= 1'b0;
					end
				end
				smtk_pkg::ST_CLEAR: begin
					count_q <= '0;
					sum_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == smtk_pkg::ST_MAX_WT) begin
			if (j_q == '0 || $signed(lr_rdata) > mx_q) begin
				mx_q <= $signed(lr_rdata);
			end
		end
		if (state_q == smtk_pkg::ST_SEL_WT) begin
			if (sel_ok && (!found_q || cand_p > bestp_q)) begin
				best_q <= j_q[AW-1:0];
				bestp_q <= cand_p;
			end
		end
		if (state_q == smtk_pkg::ST_EMIT && out_free) begin
			out_idx_q <= smtk_pkg::IDX_W'(best_q);
			out_rank_q <= smtk_pkg::IDX_W'(k_q);
			out_prob_q <= bestp_q;
			out_last_q <= (k_q + 1'b1 == want_q);
			prev_idx_q <= best_q;
			prev_p_q <= bestp_q;
		end
	end

	assign dout.valid = out_valid_q;
	assign dout.entry_index = out_idx_q;
	assign dout.rank = out_rank_q;
	assign dout.probability = out_prob_q;
	assign dout.last_result = out_last_q;
endmodule

// ===== rtl/smtk_ram.sv =====
module smtk_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/smtk_exp.sv =====
module smtk_exp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [smtk_pkg::EXP_W-1:0]   x,
	output logic                         done,
	output logic [smtk_pkg::EXP_W-1:0]   e
);
	logic [4:0]  vld_q;
	logic        zero_s1, zero_s2, zero_s3, zero_s4;
	logic [14:0] y_s1;
	logic [4:0]  n_s2, n_s3, n_s4;
	logic [3:0]  i_s2, i_s3;
	logic [11:0] lin_s2;
	logic [16:0] f_s3;
	logic [16:0] m_s4;
	logic [16:0] e_s5;
	logic [31:0] prod_y;
	logic [31:0] prod_lin;
	logic [23:0] sq;
	logic [33:0] prod_m;

	assign prod_y = 32'(x[14:0]) * 32'd94548;
	assign prod_lin = 32'(y_s1[5:0]) * 32'd45426;
	assign sq = 24'(lin_s2) * 24'(lin_s2);
	assign prod_m = 34'(smtk_pkg::pow2_lut(i_s3)) * 34'(f_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[3:0], start};
		end
	end

	always_ff @(posedge clk) begin
		zero_s1 <= x > smtk_pkg::EXP_CUTOFF;
		y_s1 <= prod_y[30:16];
		zero_s2 <= zero_s1;
		n_s2 <= y_s1[14:10];
		i_s2 <= y_s1[9:6];
		lin_s2 <= prod_lin[21:10];
		zero_s3 <= zero_s2;
		n_s3 <= n_s2;
		i_s3 <= i_s2;
		f_s3 <= 17'(18'd65536 - 18'(lin_s2) + 18'(sq[23:17]));
		zero_s4 <= zero_s3;
		n_s4 <= n_s3;
		m_s4 <= prod_m[32:16];
		e_s5 <= zero_s4 ? '0 : (m_s4 >> n_s4);
	end

	assign done = vld_q[4];
	assign e = e_s5;
endmodule

// ===== rtl/smtk_div.sv =====
module smtk_div #(
	parameter int SW = 23
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [smtk_pkg::EXP_W-1:0]   num,
	input  logic [SW-1:0]                den,
	output logic                         done,
	output logic [smtk_pkg::EXP_W-1:0]   q
);
	localparam int QW = smtk_pkg::EXP_W;
	localparam int CNW = $clog2(QW + 1);

	logic [SW:0]     rem_q;
	logic [QW-1:0]   sh_q;
	logic [QW-1:0]   q_q;
	logic [CNW-1:0]  cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [SW+1:0]   trial;
	logic            ge;

	// Quotient stays below 2^17 since num < 2*den; shift in the low 17 dividend bits
	assign trial = {rem_q, sh_q[QW-1]};
	assign ge = trial >= {1'b0, 1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= (SW+1)'(num >> 1);
			sh_q <= {num[0], {(QW-1){1'b0}}};
			q_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? (SW+1)'(trial - (SW+2)'(den)) : (SW+1)'(trial);
			sh_q <= {sh_q[QW-2:0], 1'b0};
			q_q <= {q_q[QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign q = q_q;
endmodule
